/* rtl/jtag_scan_master_macros.svh */
// Assertion macros shared by the JTAG scan master checkers.
`ifndef JTAG_SCAN_MASTER_MACROS_SVH
`define JTAG_SCAN_MASTER_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low
`define JSM_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low
`define JSM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/jsm_pkg.sv */
// Shared types and constants of the JTAG scan master.
`default_nettype none

package jsm_pkg;

    // Request kinds carried in s_tuser
    localparam logic [1:0] REQ_PLAIN = 2'd0;
    localparam logic [1:0] REQ_SCAN  = 2'd1;
    localparam logic [1:0] REQ_RESET = 2'd2;

    // TAP walk phases
    localparam int PHASE_W = 4;
    localparam logic [PHASE_W-1:0] PH_IDLE      = 4'd0;
    localparam logic [PHASE_W-1:0] PH_SEL_DR    = 4'd1;
    localparam logic [PHASE_W-1:0] PH_SEL_IR    = 4'd2;
    localparam logic [PHASE_W-1:0] PH_CAP_IR    = 4'd3;
    localparam logic [PHASE_W-1:0] PH_SHIFT_IR  = 4'd4;
    localparam logic [PHASE_W-1:0] PH_EXIT1_IR  = 4'd5;
    localparam logic [PHASE_W-1:0] PH_UPD_IR    = 4'd6;
    localparam logic [PHASE_W-1:0] PH_CAP_DR    = 4'd7;
    localparam logic [PHASE_W-1:0] PH_SHIFT_DR  = 4'd8;
    localparam logic [PHASE_W-1:0] PH_EXIT1_DR  = 4'd9;
    localparam logic [PHASE_W-1:0] PH_UPD_DR    = 4'd10;
    localparam logic [PHASE_W-1:0] PH_TAP_RESET = 4'd11;

    // Field widths
    localparam int INSTR_W = 5;
    localparam int DATA_W  = 64;
    localparam int DLEN_W  = 7;

    // Stream widths
    localparam int S_TDATA_W = 80;
    localparam int M_TDATA_W = 72;

    // One TCK cycle request
    typedef struct packed {
        logic [1:0]         req_type;
        logic [INSTR_W-1:0] instr_value;
        logic [DATA_W-1:0]  data_value;
        logic [DLEN_W-1:0]  data_length;
        logic               tdo_in;
    } jsm_item_t;

    // Pin values and status for one TCK cycle
    typedef struct packed {
        logic              tms_out;
        logic              tdi_out;
        logic              sampled;
        logic              scan_done;
        logic [DATA_W-1:0] captured_data;
        logic              busy_res;
        logic              refused;
    } jsm_result_t;

endpackage

`default_nettype wire

/* rtl/jtag_scan_master.sv */
// Top level of the JTAG scan master: request and result registers around the TAP walk.
//
//  channel | dir | handshake          | contents
//  s_*     | in  | s_tvalid/s_tready  | one TCK cycle request, kind in s_tuser
//  m_*     | out | m_tvalid/m_tready  | pin values and status, scan_done in m_tuser
//
// One request per clock while m_tready keeps up; a result shows on m_tdata once its request is taken
// and the result slot is free: the request register loads on the accepting edge, the result register on fire.
// rst_n clears the TAP walk to Run-Test/Idle and forgets the loaded instruction.
// A stalled m_tready holds the result; one more request waits in the request register
// and s_tready drops until the result is taken.
`default_nettype none

module jtag_scan_master
    import jsm_pkg::*;
#(
    parameter int IR_LEN       = 5,
    parameter int MAX_DR_LEN   = 64,
    parameter int RESET_CYCLES = 11
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 s_tvalid,
    output      logic                 s_tready,
    // instr_value[4:0], data_value[68:5], data_length[75:69], tdo_in[76], zero[79:77]
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    // req_type[1:0]
    input  wire logic [1:0]           s_tuser,
    output      logic                 m_tvalid,
    input  wire logic                 m_tready,
    // tms_out[0], tdi_out[1], sampled[2], captured_data[66:3], busy_res[67],
    // refused[68], zero[71:69]
    output      logic [M_TDATA_W-1:0] m_tdata,
    // scan_done[0]
    output      logic                 m_tuser
);

    logic        in_valid_reg, in_valid_next;
    jsm_item_t   item_reg;
    logic        out_valid_reg, out_valid_next;
    jsm_result_t out_reg;
    jsm_result_t result;
    logic        fire;

    // Step the TAP when a request is held and the result slot frees up
    assign fire     = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || fire;

    jsm_step #(
        .IR_LEN       (IR_LEN),
        .MAX_DR_LEN   (MAX_DR_LEN),
        .RESET_CYCLES (RESET_CYCLES)
    ) u_step (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (fire),
        .item   (item_reg),
        .result (result)
    );

    // Track request and result occupancy
    always_comb
    begin
        in_valid_next  = (s_tvalid && s_tready) ? 1'b1 : (fire ? 1'b0 : in_valid_reg);
        out_valid_next = fire ? 1'b1 : (m_tready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Capture the request fields
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            item_reg.req_type    <= s_tuser;
            item_reg.instr_value <= s_tdata[4:0];
            item_reg.data_value  <= s_tdata[68:5];
            item_reg.data_length <= s_tdata[75:69];
            item_reg.tdo_in      <= s_tdata[76];
        end
    end

    // Load the result
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            out_reg <= result;
        end
    end

    // Pack the result stream
    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.scan_done;
    assign m_tdata  = {3'b000, out_reg.refused, out_reg.busy_res, out_reg.captured_data,
                       out_reg.sampled, out_reg.tdi_out, out_reg.tms_out};

endmodule

`default_nettype wire

/* rtl/jsm_step.sv */
// TAP walk state and the per-cycle pin and status logic.
`default_nettype none

module jsm_step
    import jsm_pkg::*;
#(
    parameter int IR_LEN       = 5,
    parameter int MAX_DR_LEN   = 64,
    parameter int RESET_CYCLES = 11
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        fire,
    input  wire jsm_item_t   item,
    output jsm_result_t      result
);

    localparam int IRC_W = $clog2(IR_LEN + 1);
    localparam int IRI_W = $clog2(IR_LEN);
    localparam int LEN_W = $clog2(MAX_DR_LEN + 1);
    localparam int POS_W = $clog2(MAX_DR_LEN);
    localparam int RST_W = $clog2(RESET_CYCLES + 1);

    logic [PHASE_W-1:0]    phase_reg,      phase_next;
    logic [INSTR_W-1:0]    held_instr_reg, held_instr_next;
    logic                  known_reg,      known_next;
    logic [IRC_W-1:0]      ir_count_reg,   ir_count_next;
    logic [MAX_DR_LEN-1:0] shift_reg,      shift_next;
    logic [MAX_DR_LEN-1:0] cap_reg,        cap_next;
    logic [LEN_W-1:0]      dr_count_reg,   dr_count_next;
    logic [LEN_W-1:0]      req_len_reg,    req_len_next;
    logic [RST_W-1:0]      rst_count_reg,  rst_count_next;

    logic [IR_LEN-1:0]     ir_vec;
    logic [LEN_W-1:0]      len_sat;
    logic [POS_W-1:0]      top_pos;
    logic [IRC_W-1:0]      ir_count_inc;
    logic [LEN_W-1:0]      dr_count_inc;

    // Widen or trim the held instruction to the IR length
    generate
        if (IR_LEN >= INSTR_W) begin : g_ir_wide
            assign ir_vec = {{(IR_LEN - INSTR_W){1'b0}}, held_instr_reg};
        end
        else begin : g_ir_narrow
            assign ir_vec = held_instr_reg[IR_LEN-1:0];
        end
    endgenerate

    // Clamp the requested length to one .. MAX_DR_LEN
    always_comb
    begin
        if (item.data_length == '0)
        begin
            len_sat = LEN_W'(1);
        end
        else if (item.data_length > DLEN_W'(MAX_DR_LEN))
        begin
            len_sat = LEN_W'(MAX_DR_LEN);
        end
        else
        begin
            len_sat = LEN_W'(item.data_length);
        end
    end

    assign top_pos      = POS_W'(req_len_reg - LEN_W'(1));
    assign ir_count_inc = ir_count_reg + IRC_W'(1);
    assign dr_count_inc = dr_count_reg + LEN_W'(1);

    // Walk the TAP one phase per request
    always_comb
    begin
        phase_next      = phase_reg;
        held_instr_next = held_instr_reg;
        known_next      = known_reg;
        ir_count_next   = ir_count_reg;
        shift_next      = shift_reg;
        cap_next        = cap_reg;
        dr_count_next   = dr_count_reg;
        req_len_next    = req_len_reg;
        rst_count_next  = rst_count_reg;

        result               = '0;
        result.tdi_out       = 1'b1;
        result.busy_res      = 1'b1;
        result.refused       = (phase_reg != PH_IDLE) &&
                               ((item.req_type == REQ_SCAN) || (item.req_type == REQ_RESET));

        case (phase_reg)
            PH_IDLE:
            begin
                result.busy_res = 1'b0;
                if (item.req_type == REQ_SCAN)
                begin
                    result.busy_res = 1'b1;
                    result.tms_out  = 1'b1;
                    req_len_next    = len_sat;
                    shift_next      = item.data_value[MAX_DR_LEN-1:0];
                    if (!(known_reg && (held_instr_reg == item.instr_value)))
                    begin
                        held_instr_next = item.instr_value;
                        known_next      = 1'b0;
                    end
                    phase_next = PH_SEL_DR;
                end
                else if (item.req_type == REQ_RESET)
                begin
                    result.busy_res = 1'b1;
                    result.tms_out  = 1'b1;
                    rst_count_next  = RST_W'(1);
                    known_next      = 1'b0;
                    phase_next      = PH_TAP_RESET;
                end
            end
            PH_SEL_DR:
            begin
                if (!known_reg)
                begin
                    result.tms_out = 1'b1;
                    phase_next     = PH_SEL_IR;
                end
                else
                begin
                    phase_next = PH_CAP_DR;
                end
            end
            PH_SEL_IR:
            begin
                phase_next = PH_CAP_IR;
            end
            PH_CAP_IR:
            begin
                ir_count_next = '0;
                phase_next    = PH_SHIFT_IR;
            end
            PH_SHIFT_IR:
            begin
                result.tdi_out = ir_vec[ir_count_reg[IRI_W-1:0]];
                ir_count_next  = ir_count_inc;
                if (ir_count_inc >= IRC_W'(IR_LEN))
                begin
                    result.tms_out = 1'b1;
                    phase_next     = PH_EXIT1_IR;
                end
            end
            PH_EXIT1_IR:
            begin
                result.tms_out = 1'b1;
                phase_next     = PH_UPD_IR;
            end
            PH_UPD_IR:
            begin
                result.tms_out = 1'b1;
                known_next     = 1'b1;
                phase_next     = PH_SEL_DR;
            end
            PH_CAP_DR:
            begin
                cap_next      = '0;
                dr_count_next = '0;
                phase_next    = PH_SHIFT_DR;
            end
            PH_SHIFT_DR:
            begin
                // Drive LSB out, drop TDO into the top of the run
                result.tdi_out = shift_reg[0];
                result.sampled = 1'b1;
                shift_next     = shift_reg >> 1;
                cap_next       = (cap_reg >> 1) |
                                 (MAX_DR_LEN'(item.tdo_in) << top_pos);
                dr_count_next  = dr_count_inc;
                if (dr_count_inc >= req_len_reg)
                begin
                    result.tms_out = 1'b1;
                    phase_next     = PH_EXIT1_DR;
                end
            end
            PH_EXIT1_DR:
            begin
                result.tms_out = 1'b1;
                phase_next     = PH_UPD_DR;
            end
            PH_UPD_DR:
            begin
                result.scan_done     = 1'b1;
                result.captured_data = DATA_W'(cap_reg);
                phase_next           = PH_IDLE;
            end
            PH_TAP_RESET:
            begin
                if (rst_count_reg < RST_W'(RESET_CYCLES))
                begin
                    result.tms_out = 1'b1;
                    rst_count_next = rst_count_reg + RST_W'(1);
                end
                else
                begin
                    rst_count_next = '0;
                    phase_next     = PH_IDLE;
                end
            end
            default:
            begin
                result.busy_res = 1'b0;
                phase_next      = PH_IDLE;
            end
        endcase
    end

    // Advance control state on each accepted request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            held_instr_reg <= '0;
            known_reg      <= 1'b0;
            ir_count_reg   <= '0;
            dr_count_reg   <= '0;
            req_len_reg    <= '0;
            rst_count_reg  <= '0;
        end
        else if (fire)
        begin
            phase_reg      <= phase_next;
            held_instr_reg <= held_instr_next;
            known_reg      <= known_next;
            ir_count_reg   <= ir_count_next;
            dr_count_reg   <= dr_count_next;
            req_len_reg    <= req_len_next;
            rst_count_reg  <= rst_count_next;
        end
    end

    // Hold shift and capture words
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            shift_reg <= shift_next;
            cap_reg   <= cap_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/jsm_checker.sv */
// Port-level checks of the JTAG scan master and their binding.
`default_nettype none

`include "jtag_scan_master_macros.svh"

module jsm_checker
    import jsm_pkg::*;
(
    input wire logic                 clk,
    input wire logic                 rst_n,
    input wire logic                 m_tvalid,
    input wire logic                 m_tready,
    input wire logic [M_TDATA_W-1:0] m_tdata,
    input wire logic                 m_tuser
);

    // Hold a stalled result
    `JSM_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")

    // Update-DR drives TMS low inside a busy sequence
    `JSM_ASSERT_NOW(a_done_pins, m_tvalid && m_tuser, !m_tdata[0] && m_tdata[67] && !m_tdata[2], "bad pins on scan done")

    // Drop captured bits outside scan done
    `JSM_ASSERT_NOW(a_cap_zero, m_tvalid && !m_tuser, m_tdata[66:3] == 64'd0, "captured data without scan done")

    // A sampled bit or a refused request only happens while busy
    `JSM_ASSERT_NOW(a_busy_flags, m_tvalid && (m_tdata[2] || m_tdata[68]), m_tdata[67], "sample or refusal while not busy")

endmodule

bind jtag_scan_master jsm_checker u_jsm_checker (.*);

`default_nettype wire

/* verif/tb_jtag_scan_master.sv */
// Self-checking testbench for the JTAG scan master: directed table, then random TAP traffic.
`default_nettype none

module tb_jtag_scan_master;
    import jsm_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Request kind that the block treats as a plain cycle
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    localparam int IR_BITS      = 5;
    localparam int DR_MAX       = 64;
    localparam int TAP_RST_LEN  = 11;
    localparam int DIR_ROWS     = 26;
    localparam int RAND_ITEMS   = 1124;
    localparam int QUIET_LIMIT  = 2000;
    localparam int HOLD_AT      = 300;
    localparam int HOLD_CYCLES  = 80;
    localparam int DRAIN_AT     = 500;

    // Pin values on an idle cycle, and on the cycle that enters a TAP reset
    localparam jsm_result_t IDLE_PINS   = '{1'b0, 1'b1, 1'b0, 1'b0, 64'd0, 1'b0, 1'b0};
    localparam jsm_result_t RESET_ENTRY = '{1'b1, 1'b1, 1'b0, 1'b0, 64'd0, 1'b1, 1'b0};

    typedef struct {
        logic [1:0]         kind;
        logic [INSTR_W-1:0] instr;
        logic [DATA_W-1:0]  data;
        logic [DLEN_W-1:0]  len;
        logic               tdo;
        bit                 typed;
        jsm_result_t        want;
    } dir_row_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic [1:0]           s_tuser = REQ_PLAIN;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tuser;

    // Predicted TAP walk state
    logic [PHASE_W-1:0] walk_phase = PH_IDLE;
    logic [INSTR_W-1:0] ir_loaded = '0;
    logic               ir_valid = 1'b0;
    logic [2:0]         ir_bit_idx = '0;
    logic [DATA_W-1:0]  dr_out_word = '0;
    logic [DATA_W-1:0]  dr_in_word = '0;
    logic [DLEN_W-1:0]  dr_bit_idx = '0;
    logic [DLEN_W-1:0]  dr_len = '0;
    logic [3:0]         rst_cnt = '0;

    jsm_result_t pending_pins [$];
    int          mismatches = 0;
    int          rx_count = 0;
    bit          rx_hold = 1'b0;
    bit          tx_gaps_on = 1'b1;
    bit          rx_gaps_on = 1'b1;

    jtag_scan_master dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Advance the predicted TAP walk by one TCK cycle and return its pins and status
    function automatic jsm_result_t tap_walk_step(input jsm_item_t it);
        jsm_result_t r;
        logic [DLEN_W-1:0] len;
        r = '{1'b0, 1'b1, 1'b0, 1'b0, 64'd0, 1'b1, 1'b0};
        if (walk_phase != PH_IDLE && (it.req_type == REQ_SCAN || it.req_type == REQ_RESET))
            r.refused = 1'b1;
        case (walk_phase)
            PH_IDLE:
            begin
                r.busy_res = 1'b0;
                if (it.req_type == REQ_SCAN)
                begin
                    r.busy_res = 1'b1;
                    r.tms_out = 1'b1;
                    len = it.data_length;
                    if (len == 0)
                        len = 1;
                    if (len > DR_MAX)
                        len = DR_MAX;
                    dr_len = len;
                    dr_out_word = it.data_value;
                    if (!(ir_valid && ir_loaded == it.instr_value))
                    begin
                        ir_loaded = it.instr_value;
                        ir_valid = 1'b0;
                    end
                    walk_phase = PH_SEL_DR;
                end
                else if (it.req_type == REQ_RESET)
                begin
                    r.busy_res = 1'b1;
                    r.tms_out = 1'b1;
                    rst_cnt = 1;
                    ir_valid = 1'b0;
                    walk_phase = PH_TAP_RESET;
                end
            end
            PH_SEL_DR:
            begin
                if (!ir_valid)
                begin
                    r.tms_out = 1'b1;
                    walk_phase = PH_SEL_IR;
                end
                else
                    walk_phase = PH_CAP_DR;
            end
            PH_SEL_IR:
                walk_phase = PH_CAP_IR;
            PH_CAP_IR:
            begin
                ir_bit_idx = 0;
                walk_phase = PH_SHIFT_IR;
            end
            PH_SHIFT_IR:
            begin
                r.tdi_out = (ir_bit_idx < INSTR_W) ? ir_loaded[ir_bit_idx] : 1'b0;
                ir_bit_idx = ir_bit_idx + 1'b1;
                if (ir_bit_idx >= IR_BITS)
                begin
                    r.tms_out = 1'b1;
                    walk_phase = PH_EXIT1_IR;
                end
            end
            PH_EXIT1_IR:
            begin
                r.tms_out = 1'b1;
                walk_phase = PH_UPD_IR;
            end
            PH_UPD_IR:
            begin
                r.tms_out = 1'b1;
                ir_valid = 1'b1;
                walk_phase = PH_SEL_DR;
            end
            PH_CAP_DR:
            begin
                dr_in_word = '0;
                dr_bit_idx = '0;
                walk_phase = PH_SHIFT_DR;
            end
            PH_SHIFT_DR:
            begin
                len = dr_len;
                if (len == 0)
                    len = 1;
                if (len > DR_MAX)
                    len = DR_MAX;
                r.tdi_out = dr_out_word[0];
                dr_out_word = dr_out_word >> 1;
                r.sampled = 1'b1;
                dr_in_word = (dr_in_word >> 1) | (64'(it.tdo_in) << (len - 1));
                dr_bit_idx = dr_bit_idx + 1'b1;
                if (dr_bit_idx >= len)
                begin
                    r.tms_out = 1'b1;
                    walk_phase = PH_EXIT1_DR;
                end
            end
            PH_EXIT1_DR:
            begin
                r.tms_out = 1'b1;
                walk_phase = PH_UPD_DR;
            end
            PH_UPD_DR:
            begin
                r.scan_done = 1'b1;
                r.captured_data = dr_in_word;
                walk_phase = PH_IDLE;
            end
            PH_TAP_RESET:
            begin
                if (rst_cnt < TAP_RST_LEN)
                begin
                    r.tms_out = 1'b1;
                    rst_cnt = rst_cnt + 1'b1;
                end
                else
                begin
                    rst_cnt = '0;
                    walk_phase = PH_IDLE;
                end
            end
            default:
            begin
                walk_phase = PH_IDLE;
                r.busy_res = 1'b0;
            end
        endcase
        return r;
    endfunction

    function automatic void compare_field(input string name, input logic [63:0] want,
                                          input logic [63:0] got);
        if (want !== got)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
        end
    endfunction

    // Offer one request; on acceptance predict it and queue the expected pins
    task automatic offer_request(input jsm_item_t it, input bit typed, input jsm_result_t want);
        int gap;
        jsm_result_t pred;
        gap = (tx_gaps_on && !rx_hold) ? $urandom_range(0, 18) : 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {3'b000, it.tdo_in, it.data_length, it.data_value, it.instr_value};
        s_tuser  <= it.req_type;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        pred = tap_walk_step(it);
        pending_pins.push_back(typed ? want : pred);
    endtask

    // Request side: directed table, then random scans, resets and noise
    initial
    begin
        dir_row_t dir_tbl [DIR_ROWS];
        jsm_item_t it;
        int roll;
        dir_tbl = '{
            '{REQ_PLAIN,  5'd0,  64'd0,            7'd1,   1'b0, 1'b1, IDLE_PINS},
            '{REQ_UNUSED, 5'd31, {64{1'b1}},       7'd127, 1'b1, 1'b1, IDLE_PINS},
            // scan with the widest instruction, length zero taken as one bit
            '{REQ_SCAN,   5'd31, {64{1'b1}},       7'd0,   1'b0, 1'b0, IDLE_PINS},
            '{REQ_PLAIN,  5'd0,  64'd0,            7'd1,   1'b1, 1'b0, IDLE_PINS},
            // start requests while busy are refused
            '{REQ_SCAN,   5'd0,  64'd0,            7'd64,  1'b0, 1'b0, IDLE_PINS},
            '{REQ_RESET,  5'd0,  64'd0,            7'd1,   1'b1, 1'b0, IDLE_PINS},
            '{REQ_PLAIN,  5'd0,  64'd0,            7'd1,   1'b1, 1'b0, IDLE_PINS},
            '{REQ_PLAIN,  5'd0,  64'd0,            7'd1,   1'b0, 1'b0, IDLE_PINS},
            '{REQ_PLAIN,  5'd0,  64'd0,            7'd1,   1'b1, 1'b0, IDLE_PINS},
            '{REQ_PLAIN,  5'd0,  64'd0,            7'd1,   1'b0, 1'b0, IDLE_PINS},
            '{REQ_PLAIN,  5'd0,  64'd0,            7'd1,   1'b1, 1'b0, IDLE_PINS},
            '{REQ_UNUSED, 5'd0,  64'd0,            7'd1,   1'b0, 1'b0, IDLE_PINS},
            '{REQ_PLAIN,  5'd0,  64'd0,            7'd1,   1'b0, 1'b0, IDLE_PINS},
            '{REQ_PLAIN,  5'd0,  64'd0,            7'd1,   1'b0, 1'b0, IDLE_PINS},
            '{REQ_PLAIN,  5'd0,  64'd0,            7'd1,   1'b0, 1'b0, IDLE_PINS},
            '{REQ_PLAIN,  5'd0,  64'd0,            7'd1,   1'b1, 1'b0, IDLE_PINS},
            '{REQ_PLAIN,  5'd0,  64'd0,            7'd1,   1'b0, 1'b0, IDLE_PINS},
            '{REQ_PLAIN,  5'd0,  64'd0,            7'd1,   1'b0, 1'b0, IDLE_PINS},
            // TAP reset from idle
            '{REQ_RESET,  5'd0,  64'd0,            7'd1,   1'b0, 1'b1, RESET_ENTRY},
            '{REQ_PLAIN,  5'd0,  64'd0,            7'd1,   1'b1, 1'b0, IDLE_PINS},
            '{REQ_PLAIN,  5'd0,  64'd0,            7'd1,   1'b0, 1'b0, IDLE_PINS},
            '{REQ_UNUSED, 5'd0,  64'd0,            7'd1,   1'b1, 1'b0, IDLE_PINS},
            '{REQ_PLAIN,  5'd0,  64'd0,            7'd1,   1'b0, 1'b0, IDLE_PINS},
            '{REQ_PLAIN,  5'd0,  64'd0,            7'd1,   1'b1, 1'b0, IDLE_PINS},
            '{REQ_PLAIN,  5'd0,  64'd0,            7'd1,   1'b0, 1'b0, IDLE_PINS},
            '{REQ_SCAN,   5'd21, 64'd0,            7'd127, 1'b1, 1'b0, IDLE_PINS}
        };

        while (!rst_n)
            @(posedge clk);
        @(posedge clk);

        // Walk the directed table
        for (int i = 0; i < DIR_ROWS; i++)
        begin
            it.req_type    = dir_tbl[i].kind;
            it.instr_value = dir_tbl[i].instr;
            it.data_value  = dir_tbl[i].data;
            it.data_length = dir_tbl[i].len;
            it.tdo_in      = dir_tbl[i].tdo;
            offer_request(it, dir_tbl[i].typed, dir_tbl[i].want);
        end

        // Random part, shaped on the predicted phase
        for (int n = 0; n < RAND_ITEMS; n++)
        begin
            if (n % 50 == 0)
                tx_gaps_on = ($urandom_range(0, 2) != 0);
            if (n == DRAIN_AT)
            begin
                // hold off until every queued result has come back
                s_tvalid <= 1'b0;
                do
                    @(posedge clk);
                while (pending_pins.size() != 0);
            end

            roll = $urandom_range(0, 99);
            it.instr_value = ($urandom_range(0, 1) == 1) ? ir_loaded : INSTR_W'($urandom);
            case ($urandom_range(0, 7))
                0:       it.data_value = '0;
                1:       it.data_value = '1;
                default: it.data_value = {$urandom, $urandom};
            endcase
            roll = roll;
            case ($urandom_range(0, 9))
                0:       it.data_length = DLEN_W'(DR_MAX);
                1:       it.data_length = DLEN_W'($urandom_range(DR_MAX + 1, 127));
                2, 3:    it.data_length = DLEN_W'($urandom_range(9, DR_MAX - 1));
                default: it.data_length = DLEN_W'($urandom_range(0, 8));
            endcase
            it.tdo_in = 1'($urandom);

            if (walk_phase == PH_IDLE)
            begin
                if (roll < 72)
                    it.req_type = REQ_SCAN;
                else if (roll < 82)
                    it.req_type = REQ_RESET;
                else if (roll < 94)
                    it.req_type = REQ_PLAIN;
                else
                    it.req_type = REQ_UNUSED;
            end
            else
            begin
                if (roll < 80)
                    it.req_type = REQ_PLAIN;
                else if (roll < 88)
                    it.req_type = REQ_UNUSED;
                else if (roll < 95)
                    it.req_type = REQ_SCAN;
                else
                    it.req_type = REQ_RESET;
            end
            offer_request(it, 1'b0, IDLE_PINS);
        end

        // Drain, then let the pipeline settle
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (pending_pins.size() != 0);
        repeat (8) @(posedge clk);

        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // Result side: random stalls, one long hold, field-by-field compare
    initial
    begin
        jsm_result_t got;
        jsm_result_t want;
        int stall;
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (rx_count % 40 == 0)
                rx_gaps_on = ($urandom_range(0, 2) != 0);
            if (rx_count == HOLD_AT)
            begin
                rx_hold = 1'b1;
                stall = HOLD_CYCLES;
            end
            else
                stall = rx_gaps_on ? $urandom_range(0, 18) : 0;
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rx_hold = 1'b0;
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid)
                @(posedge clk);

            got.tms_out       = m_tdata[0];
            got.tdi_out       = m_tdata[1];
            got.sampled       = m_tdata[2];
            got.captured_data = m_tdata[66:3];
            got.busy_res      = m_tdata[67];
            got.refused       = m_tdata[68];
            got.scan_done     = m_tuser;
            rx_count++;

            if (pending_pins.size() == 0)
            begin
                $error("result with no request pending");
                mismatches++;
            end
            else
            begin
                want = pending_pins.pop_front();
                compare_field("tms_out", 64'(want.tms_out), 64'(got.tms_out));
                compare_field("tdi_out", 64'(want.tdi_out), 64'(got.tdi_out));
                compare_field("sampled", 64'(want.sampled), 64'(got.sampled));
                compare_field("scan_done", 64'(want.scan_done), 64'(got.scan_done));
                compare_field("captured_data", want.captured_data, got.captured_data);
                compare_field("busy_res", 64'(want.busy_res), 64'(got.busy_res));
                compare_field("refused", 64'(want.refused), 64'(got.refused));
            end
        end
    end

    // Watchdog: end the run when nothing moves for too long
    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("Some tests failed");
        $finish;
    end

endmodule

`default_nettype wire
